// ===== rtl/cosine_similarity_gallery_match_core_macros.svh =====
// assertion macros for the cosine similarity gallery match core
`ifndef COSINE_SIMILARITY_GALLERY_MATCH_CORE_MACROS_SVH
`define COSINE_SIMILARITY_GALLERY_MATCH_CORE_MACROS_SVH

// same-cycle implication
`define CSGM_CHECK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSGM_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csgm_pkg.sv =====
// types, constants and helpers shared by the gallery match core
`timescale 1ns / 1ps

package csgm_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_ENROLL = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         entry_index;
        logic [11:0]        elem_index;
        logic signed [31:0] elem_value;
        logic               elem_is_nan;
        logic [30:0]        entry_id;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic        match_found;
        logic [30:0] match_id;
        logic [3:0]  match_entry;
        logic [14:0] match_score;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SC_ISSUE,
        ST_SC_WAIT,
        ST_REPORT
    } t_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_CHECK,
        SC_DIV,
        SC_SQRT,
        SC_DONE
    } t_sc_state;

    typedef struct packed {
        logic load;
        logic do_write;
        logic do_enroll;
        logic do_remove;
        logic scan_start;
        logic sc_begin;
        logic sc_go;
        logic sc_take;
        logic sc_next;
        logic report;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic pos_ok;
        logic last;
        logic scan_busy;
        logic sc_done;
        logic sc_last;
    } t_dp_status;

    localparam logic signed [31:0] ELEM_LIMIT   = 32'sd16384000;
    localparam logic [14:0]        THRESH_RESET = 15'd29491;
    localparam logic [14:0]        SCORE_MAX    = 15'd32767;

    function automatic logic [63:0] sat_add_u(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add_s(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            return {1'b0, {63{1'b1}}};
        end
        if (a[63] && b[63] && !s[63]) begin
            return {1'b1, {63{1'b0}}};
        end
        return s;
    endfunction

endpackage

// ===== rtl/csgm_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module csgm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/csgm_score.sv =====
// iterative cosine score unit: wide products, restoring divide, integer square root
`timescale 1ns / 1ps

module csgm_score (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic signed [63:0] i_dot,
    input  logic [63:0]        i_qn,
    input  logic [63:0]        i_gn,
    output logic               o_done,
    output logic [14:0]        o_score
);

    csgm_pkg::t_sc_state r_state, n_state;

    logic [63:0]  r_d, r_qn, r_gn;
    logic [4:0]   r_cnt;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic         r_pp_tgt;
    logic         r_pp_v;
    logic [127:0] r_p, r_dsq;
    logic [157:0] r_rem, r_div;
    logic [29:0]  r_quo;
    logic [14:0]  r_root;

    logic [2:0]   w_k;
    logic [63:0]  w_x, w_y;
    logic [31:0]  w_a, w_b;
    logic [63:0]  w_prod;
    logic [127:0] w_add;
    logic [157:0] w_num, w_den;
    logic [14:0]  w_trial;
    logic [29:0]  w_sq;
    logic         w_zero;

    // step k: k[2] picks norms product or dot square, k[1:0] pick limbs
    assign w_k    = r_cnt[2:0];
    assign w_x    = w_k[2] ? r_d : r_qn;
    assign w_y    = w_k[2] ? r_d : r_gn;
    assign w_a    = w_k[1] ? w_x[63:32] : w_x[31:0];
    assign w_b    = w_k[0] ? w_y[63:32] : w_y[31:0];
    assign w_prod = 64'(w_a) * 64'(w_b);
    assign w_add  = 128'(r_pp) << (7'(r_pp_sh) * 7'd32);

    assign w_num   = {r_dsq, 30'd0};
    assign w_den   = {r_p, 30'd0};
    assign w_trial = r_root | (15'd1 << r_cnt[3:0]);
    assign w_sq    = 30'(w_trial) * 30'(w_trial);
    assign w_zero  = (i_dot <= 64'sd0) || (i_qn == 64'd0) || (i_gn == 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csgm_pkg::SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            csgm_pkg::SC_IDLE: begin
                if (i_go) begin
                    n_state = w_zero ? csgm_pkg::SC_DONE : csgm_pkg::SC_MUL;
                end
            end
            csgm_pkg::SC_MUL: begin
                if (r_cnt == 5'd8) begin
                    n_state = csgm_pkg::SC_CHECK;
                end
            end
            csgm_pkg::SC_CHECK: begin
                n_state = (w_num >= w_den) ? csgm_pkg::SC_DONE : csgm_pkg::SC_DIV;
            end
            csgm_pkg::SC_DIV: begin
                if (r_cnt == 5'd29) begin
                    n_state = csgm_pkg::SC_SQRT;
                end
            end
            csgm_pkg::SC_SQRT: begin
                if (r_cnt == 5'd0) begin
                    n_state = csgm_pkg::SC_DONE;
                end
            end
            csgm_pkg::SC_DONE: begin
                n_state = csgm_pkg::SC_IDLE;
            end
            default: begin
                n_state = csgm_pkg::SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_v <= 1'b0;
        end else begin
            r_pp_v <= (r_state == csgm_pkg::SC_MUL) && (r_cnt < 5'd8);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp     <= w_prod;
        r_pp_sh  <= 2'(w_k[1]) + 2'(w_k[0]);
        r_pp_tgt <= w_k[2];
        case (r_state)
            csgm_pkg::SC_IDLE: begin
                if (i_go) begin
                    r_d    <= i_dot;
                    r_qn   <= i_qn;
                    r_gn   <= i_gn;
                    r_cnt  <= 5'd0;
                    r_p    <= '0;
                    r_dsq  <= '0;
                    r_root <= '0;
                end
            end
            csgm_pkg::SC_MUL: begin
                if (r_cnt < 5'd8) begin
                    r_cnt <= r_cnt + 5'd1;
                end
                if (r_pp_v) begin
                    if (r_pp_tgt) begin
                        r_dsq <= r_dsq + w_add;
                    end else begin
                        r_p <= r_p + w_add;
                    end
                end
            end
            csgm_pkg::SC_CHECK: begin
                // quotient at or above 2^30 means the score clamps
                r_root <= csgm_pkg::SCORE_MAX;
                r_rem  <= w_num;
                r_div  <= {1'b0, r_p, 29'd0};
                r_quo  <= '0;
                r_cnt  <= 5'd0;
            end
            csgm_pkg::SC_DIV: begin
                if (r_rem >= r_div) begin
                    r_rem <= r_rem - r_div;
                    r_quo <= {r_quo[28:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[28:0], 1'b0};
                end
                r_div <= r_div >> 1;
                if (r_cnt == 5'd29) begin
                    r_cnt  <= 5'd14;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            csgm_pkg::SC_SQRT: begin
                if (w_sq <= r_quo) begin
                    r_root <= w_trial;
                end
                if (r_cnt != 5'd0) begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done  = (r_state == csgm_pkg::SC_DONE);
    assign o_score = r_root;

endmodule

// ===== rtl/csgm_datapath.sv =====
// gallery store, per-entry accumulators, shared mac and best-match selection
`timescale 1ns / 1ps

module csgm_datapath #(
    parameter int ENTRIES = 16,
    parameter int VEC_LEN = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  csgm_pkg::t_in_item     i_item,
    input  logic                   i_cfg_we,
    input  logic [14:0]            i_cfg_wdata,
    input  csgm_pkg::t_dp_cmd      i_cmd,
    output csgm_pkg::t_dp_status   o_status,
    output logic                   o_result_valid,
    output csgm_pkg::t_out_item    o_result
);

    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW    = $clog2(VEC_LEN);
    localparam int DEPTH = ENTRIES * (2 ** PW);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [EW-1:0] LAST_E = EW'(ENTRIES - 1);

    csgm_pkg::t_in_item r_item;
    logic [14:0]        r_thresh;

    logic               w_ent_ok, w_pos_ok, w_qgood, w_ggood;
    logic [EW-1:0]      w_ent;
    logic [PW-1:0]      w_pos;
    logic [32:0]        w_gal;
    logic signed [31:0] w_g;

    logic                      r_scan_act, r_s1_v, r_s2_v, r_qq_v;
    logic [EW-1:0]             r_scan_e, r_s1_e, r_s2_e;
    logic [63:0]               r_gg, r_qq;
    logic signed [63:0]        r_qg;
    logic signed [63:0]        w_gg, w_qg, w_qq;

    logic signed [63:0] r_dot [ENTRIES];
    logic [63:0]        r_gn  [ENTRIES];
    logic [63:0]        r_qn;
    logic               r_valid [ENTRIES];
    logic [30:0]        r_ids   [ENTRIES];

    logic [EW-1:0] r_sc_e;
    logic          r_found;
    logic [14:0]   r_best;
    logic [EW-1:0] r_best_e;
    logic [30:0]   r_best_id;
    logic          w_sc_done;
    logic [14:0]   w_sc_score;

    logic                r_out_valid;
    csgm_pkg::t_out_item r_out;

    assign w_ent_ok = {28'd0, r_item.entry_index} < 32'(ENTRIES);
    assign w_pos_ok = {20'd0, r_item.elem_index} < 32'(VEC_LEN);
    assign w_ent    = EW'(r_item.entry_index);
    assign w_pos    = r_item.elem_index[PW-1:0];
    assign w_qgood  = !r_item.elem_is_nan && (r_item.elem_value <= csgm_pkg::ELEM_LIMIT)
                      && (r_item.elem_value >= -csgm_pkg::ELEM_LIMIT);
    assign w_g      = w_gal[31:0];
    assign w_ggood  = !w_gal[32] && (w_g <= csgm_pkg::ELEM_LIMIT)
                      && (w_g >= -csgm_pkg::ELEM_LIMIT);
    assign w_gg     = w_g * w_g;
    assign w_qg     = r_item.elem_value * w_g;
    assign w_qq     = r_item.elem_value * r_item.elem_value;

    csgm_ram #(
        .WIDTH (33),
        .DEPTH (DEPTH)
    ) u_gallery (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_write && w_ent_ok && w_pos_ok),
        .i_waddr (AW'({w_ent, w_pos})),
        .i_wdata ({r_item.elem_is_nan, r_item.elem_value}),
        .i_raddr (AW'({r_scan_e, w_pos})),
        .o_rdata (w_gal)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= csgm_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // read, multiply, accumulate: one entry enters per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act <= 1'b0;
            r_scan_e   <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_qq_v     <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_act <= 1'b1;
                r_scan_e   <= '0;
            end else if (r_scan_act) begin
                if (r_scan_e == LAST_E) begin
                    r_scan_act <= 1'b0;
                end
                r_scan_e <= r_scan_e + 1'b1;
            end
            r_s1_v <= r_scan_act;
            r_s2_v <= r_s1_v && w_ggood;
            r_qq_v <= i_cmd.scan_start && w_qgood;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_e <= r_scan_e;
        r_s2_e <= r_s1_e;
        r_gg   <= w_gg;
        r_qg   <= w_qg;
        r_qq   <= w_qq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.report) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_dot[i] <= '0;
                r_gn[i]  <= '0;
            end
            r_qn <= '0;
        end else begin
            if (r_s2_v) begin
                r_gn[r_s2_e] <= csgm_pkg::sat_add_u(r_gn[r_s2_e], r_gg);
                if (w_qgood) begin
                    r_dot[r_s2_e] <= csgm_pkg::sat_add_s(r_dot[r_s2_e], r_qg);
                end
            end
            if (r_qq_v) begin
                r_qn <= csgm_pkg::sat_add_u(r_qn, r_qq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (w_ent_ok) begin
            if (i_cmd.do_enroll) begin
                r_valid[w_ent] <= 1'b1;
            end else if (i_cmd.do_remove) begin
                r_valid[w_ent] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_enroll && w_ent_ok) begin
            r_ids[w_ent] <= r_item.entry_id;
        end
    end

    csgm_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sc_go),
        .i_dot   (r_dot[r_sc_e]),
        .i_qn    (r_qn),
        .i_gn    (r_gn[r_sc_e]),
        .o_done  (w_sc_done),
        .o_score (w_sc_score)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_e    <= '0;
            r_found   <= 1'b0;
            r_best    <= '0;
            r_best_e  <= '0;
            r_best_id <= '0;
        end else if (i_cmd.sc_begin) begin
            r_sc_e    <= '0;
            r_found   <= 1'b0;
            r_best    <= '0;
            r_best_e  <= '0;
            r_best_id <= '0;
        end else begin
            // strict compare keeps the earliest entry on ties
            if (i_cmd.sc_take && r_valid[r_sc_e] && (w_sc_score > r_thresh)
                && (!r_found || (w_sc_score > r_best))) begin
                r_found   <= 1'b1;
                r_best    <= w_sc_score;
                r_best_e  <= r_sc_e;
                r_best_id <= r_ids[r_sc_e];
            end
            if (i_cmd.sc_next) begin
                r_sc_e <= r_sc_e + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out.match_found <= r_found;
            r_out.match_id    <= r_best_id;
            r_out.match_entry <= 4'(r_best_e);
            r_out.match_score <= r_best;
        end
    end

    assign o_status.req       = csgm_pkg::t_req'(r_item.req_type);
    assign o_status.pos_ok    = w_pos_ok;
    assign o_status.last      = r_item.last;
    assign o_status.scan_busy = r_scan_act || r_s1_v || r_s2_v || r_qq_v;
    assign o_status.sc_done   = w_sc_done;
    assign o_status.sc_last   = (r_sc_e == LAST_E);

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ===== rtl/csgm_ctrl.sv =====
// controller state machine sequencing requests, scans and scoring
`timescale 1ns / 1ps

module csgm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  csgm_pkg::t_dp_status i_status,
    output logic                 o_busy,
    output csgm_pkg::t_dp_cmd    o_cmd
);

    csgm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csgm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            csgm_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = csgm_pkg::ST_DECODE;
                end
            end
            csgm_pkg::ST_DECODE: begin
                n_state = csgm_pkg::ST_IDLE;
                case (i_status.req)
                    csgm_pkg::REQ_WRITE:  o_cmd.do_write  = 1'b1;
                    csgm_pkg::REQ_ENROLL: o_cmd.do_enroll = 1'b1;
                    csgm_pkg::REQ_REMOVE: o_cmd.do_remove = 1'b1;
                    csgm_pkg::REQ_QUERY: begin
                        if (i_status.pos_ok) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = csgm_pkg::ST_SCAN;
                        end else if (i_status.last) begin
                            o_cmd.sc_begin = 1'b1;
                            n_state        = csgm_pkg::ST_SC_ISSUE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            csgm_pkg::ST_SCAN: begin
                if (!i_status.scan_busy) begin
                    if (i_status.last) begin
                        o_cmd.sc_begin = 1'b1;
                        n_state        = csgm_pkg::ST_SC_ISSUE;
                    end else begin
                        n_state = csgm_pkg::ST_IDLE;
                    end
                end
            end
            csgm_pkg::ST_SC_ISSUE: begin
                o_cmd.sc_go = 1'b1;
                n_state     = csgm_pkg::ST_SC_WAIT;
            end
            csgm_pkg::ST_SC_WAIT: begin
                if (i_status.sc_done) begin
                    o_cmd.sc_take = 1'b1;
                    if (i_status.sc_last) begin
                        n_state = csgm_pkg::ST_REPORT;
                    end else begin
                        o_cmd.sc_next = 1'b1;
                        n_state       = csgm_pkg::ST_SC_ISSUE;
                    end
                end
            end
            csgm_pkg::ST_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = csgm_pkg::ST_IDLE;
            end
            default: begin
                n_state = csgm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != csgm_pkg::ST_IDLE);

endmodule

// ===== rtl/cosine_similarity_gallery_match_core.sv =====
// top level of the cosine similarity gallery match core
`timescale 1ns / 1ps
`include "cosine_similarity_gallery_match_core_macros.svh"

// A request is taken when start is high and busy is low. For each query element, every
// entry's stored element is read in turn from the single gallery ram port and goes through
// one shared multiply-accumulate pipeline. On the last query element each entry is then
// scored one after another by an iterative unit (64-bit products on one 32x32 multiplier,
// a 30-step restoring divide and a 15-step square root). The result appears on o_result
// for exactly one cycle with o_result_valid high and is not held: the receiver has to take
// it then. The threshold may be written whenever the block is idle.
module cosine_similarity_gallery_match_core #(
    parameter int ENTRIES = 16,
    parameter int VEC_LEN = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  csgm_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [14:0]         i_cfg_wdata,
    output logic                o_result_valid,
    output csgm_pkg::t_out_item o_result
);

    csgm_pkg::t_dp_cmd    w_cmd;
    csgm_pkg::t_dp_status w_status;

    csgm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    csgm_datapath #(
        .ENTRIES (ENTRIES),
        .VEC_LEN (VEC_LEN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    `CSGM_CHECK_NOW(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy, "result while busy")
    `CSGM_CHECK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after transfer")
    `CSGM_CHECK_NEXT(a_single_pulse, i_clk, i_rst_n, o_result_valid, !o_result_valid, "double result")
    `CSGM_CHECK_NOW(a_no_match_zero, i_clk, i_rst_n, o_result_valid && !o_result.match_found, (o_result.match_score == 15'd0) && (o_result.match_id == 31'd0), "nonzero miss")

endmodule
